// ----- rtl/p1tf_pkg.sv -----
// Shared constants and types for the P1 telegram framer.
package p1tf_pkg;

    // Default upper bound on the frame limit register
    localparam int MAX_FRAME_DEF = 4096;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FLEN_W   = 13;
    localparam int FLIM_W   = 13;
    localparam int FAIL_W   = 16;
    localparam int FCNT_W   = 17;
    localparam int TIDX_W   = 3;
    localparam int CIDX_W   = 8;
    localparam int CDATA_W  = 16;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [STATUS_W-1:0] t_status;

    // Framing characters
    localparam t_byte CH_START = 8'h2F;  // '/'
    localparam t_byte CH_END   = 8'h21;  // '!'
    localparam t_byte CH_CR    = 8'h0D;  // CR

    // Result status codes
    localparam t_status ST_IGNORED = 3'd0;
    localparam t_status ST_BYTE    = 3'd1;
    localparam t_status ST_OLD     = 3'd2;
    localparam t_status ST_NEW     = 3'd3;
    localparam t_status ST_BAD     = 3'd4;
    localparam t_status ST_OVER    = 3'd5;

    // Framer phases
    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_BODY  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;

    // Trailer positions with special meaning
    localparam logic [TIDX_W-1:0] TI_FIRST  = 3'd0;
    localparam logic [TIDX_W-1:0] TI_SECOND = 3'd1;
    localparam logic [TIDX_W-1:0] TI_CRC_CR = 3'd4;
    localparam logic [TIDX_W-1:0] TI_LAST   = 3'd5;

    // Old and new style trailer lengths
    localparam int TRAIL_OLD = 2;
    localparam int TRAIL_NEW = 6;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_FRAME_LIMIT = 8'd0;
    localparam logic [CIDX_W-1:0] REG_FAIL_LIMIT  = 8'd1;

    // Register reset values
    localparam logic [FLIM_W-1:0] FRAME_LIMIT_RST = 13'd4096;
    localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST  = 16'd4096;

endpackage

// ----- rtl/p1_telegram_framer.sv -----
// P1 telegram framer: hunts for '/', passes the body, checks the trailer.
//
// Channels
//   Input: one received byte per beat on i_rx_byte, i_in_valid/o_in_stall.
//   Output: exactly one result beat per input beat (byte echoed, status,
//   frame length on a completed frame, give-up flag), o_out_valid/i_out_stall.
//   Config: i_cfg_valid/o_cfg_ready with index and data; index 0 is
//   frame_limit, 1 is fail_limit, others are ignored. o_cfg_ready is always
//   high; a write takes effect for the next byte.
// Result register and throughput
//   Each result is registered. One byte per cycle is sustained unless the
//   receiver stalls: the state update is a compare, an add on the fail
//   counter and a small decode between framer state and the result register.
// Stall
//   While the result register is full and the receiver stalls, o_in_stall is
//   high; otherwise a new byte enters in the cycle the held result leaves.
// Reset
//   i_rst_n (synchronous, active low) empties the result register, returns to
//   hunting, clears both counters and reloads both limits with 4096.
module p1_telegram_framer
    import p1tf_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input bytes
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    // results
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [BYTE_W-1:0]   o_byte_out,
    output logic [STATUS_W-1:0] o_status,
    output logic [FLEN_W-1:0]   o_frame_length,
    output logic                o_gave_up,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CDATA_W-1:0]  i_cfg_data
);

    // The effective limit never exceeds what the 13-bit register can hold.
    localparam int LIM_MAXREG = (1 << FLIM_W) - 1;
    localparam int LIM_CAP    = (MAX_FRAME < LIM_MAXREG) ? MAX_FRAME : LIM_MAXREG;
    localparam int CNT_W      = $clog2(LIM_CAP + 1);
    localparam int SUM_W      = $clog2(LIM_CAP + TRAIL_NEW + 1);

    // configuration registers
    logic [FLIM_W-1:0] r_frame_limit;
    logic [FAIL_W-1:0] r_fail_limit;

    // framer state
    logic [1:0]        r_phase,     n_phase;
    logic [TIDX_W-1:0] r_trail_idx, n_trail_idx;
    logic              r_cr_seen,   n_cr_seen;
    logic [CNT_W-1:0]  r_byte_cnt,  n_byte_cnt;
    logic [FCNT_W-1:0] r_fail_cnt,  n_fail_cnt;

    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_byte_out;
    t_status           r_status,    n_status;
    logic [FLEN_W-1:0] r_flen,      n_flen;
    logic              r_gave_up,   n_gave_up;

    logic              in_accept;
    logic [CNT_W-1:0]  limit_eff;
    logic [SUM_W-1:0]  cnt_old_len;
    logic [SUM_W-1:0]  cnt_new_len;
    logic              do_drop;
    logic [SUM_W-1:0]  drop_bytes;
    logic [FCNT_W-1:0] fail_sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;

    // limit = min(frame_limit, MAX_FRAME); zero behaves like one since a
    // frame already holds its start byte
    assign limit_eff = (r_frame_limit > FLIM_W'(LIM_CAP)) ? CNT_W'(LIM_CAP)
                                                          : CNT_W'(r_frame_limit);

    assign cnt_old_len = SUM_W'(r_byte_cnt) + SUM_W'(TRAIL_OLD);
    assign cnt_new_len = SUM_W'(r_byte_cnt) + SUM_W'(TRAIL_NEW);
    assign fail_sum    = r_fail_cnt + FCNT_W'(drop_bytes);

    always_comb begin
        n_phase     = r_phase;
        n_trail_idx = r_trail_idx;
        n_cr_seen   = r_cr_seen;
        n_byte_cnt  = r_byte_cnt;
        n_fail_cnt  = r_fail_cnt;
        n_status    = ST_IGNORED;
        n_flen      = '0;
        n_gave_up   = 1'b0;
        do_drop     = 1'b0;
        drop_bytes  = '0;

        unique case (r_phase)
            PH_BODY: begin
                if (r_byte_cnt < limit_eff) begin
                    n_byte_cnt = r_byte_cnt + CNT_W'(1);
                    n_status   = ST_BYTE;
                    if (i_rx_byte == CH_END) begin
                        n_phase     = PH_TRAIL;
                        n_trail_idx = '0;
                        n_cr_seen   = 1'b0;
                    end
                end else begin
                    // overflow: the byte that hit the limit is not counted
                    n_status   = ST_OVER;
                    do_drop    = 1'b1;
                    drop_bytes = SUM_W'(r_byte_cnt);
                end
            end
            PH_TRAIL: begin
                n_status = ST_BYTE;
                if (r_trail_idx == TI_FIRST || r_trail_idx == TI_CRC_CR) begin
                    n_cr_seen   = (i_rx_byte == CH_CR);
                    n_trail_idx = r_trail_idx + TIDX_W'(1);
                end else if (r_trail_idx == TI_SECOND && r_cr_seen) begin
                    n_status   = ST_OLD;
                    n_flen     = FLEN_W'(cnt_old_len);
                    n_fail_cnt = '0;
                    n_phase    = PH_HUNT;
                    n_byte_cnt = '0;
                    n_trail_idx = '0;
                    n_cr_seen  = 1'b0;
                end else if (r_trail_idx >= TI_LAST) begin
                    if (r_cr_seen) begin
                        n_status    = ST_NEW;
                        n_flen      = FLEN_W'(cnt_new_len);
                        n_fail_cnt  = '0;
                        n_phase     = PH_HUNT;
                        n_byte_cnt  = '0;
                        n_trail_idx = '0;
                        n_cr_seen   = 1'b0;
                    end else begin
                        n_status   = ST_BAD;
                        do_drop    = 1'b1;
                        drop_bytes = cnt_new_len;
                    end
                end else begin
                    n_trail_idx = r_trail_idx + TIDX_W'(1);
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (i_rx_byte == CH_START) begin
                    n_phase     = PH_BODY;
                    n_byte_cnt  = CNT_W'(1);
                    n_trail_idx = '0;
                    n_cr_seen   = 1'b0;
                    n_status    = ST_BYTE;
                end
            end
        endcase

        // dropped frame: account bytes, check give-up, back to hunting
        if (do_drop) begin
            n_phase     = PH_HUNT;
            n_byte_cnt  = '0;
            n_trail_idx = '0;
            n_cr_seen   = 1'b0;
            if (r_fail_limit != '0 && fail_sum >= FCNT_W'(r_fail_limit)) begin
                n_fail_cnt = '0;
                n_gave_up  = 1'b1;
            end else begin
                n_fail_cnt = fail_sum;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RST;
            r_fail_limit  <= FAIL_LIMIT_RST;
            r_phase       <= PH_HUNT;
            r_trail_idx   <= '0;
            r_cr_seen     <= 1'b0;
            r_byte_cnt    <= '0;
            r_fail_cnt    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_FRAME_LIMIT) begin
                    r_frame_limit <= i_cfg_data[FLIM_W-1:0];
                end else if (i_cfg_index == REG_FAIL_LIMIT) begin
                    r_fail_limit <= i_cfg_data[FAIL_W-1:0];
                end
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_trail_idx <= n_trail_idx;
                r_cr_seen   <= n_cr_seen;
                r_byte_cnt  <= n_byte_cnt;
                r_fail_cnt  <= n_fail_cnt;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte_out <= i_rx_byte;
            r_status   <= n_status;
            r_flen     <= n_flen;
            r_gave_up  <= n_gave_up;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_byte_out;
    assign o_status       = r_status;
    assign o_frame_length = r_flen;
    assign o_gave_up      = r_gave_up;

    // give-up only ever accompanies a dropped frame
    a_gave_up_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_gave_up) |-> (r_status == ST_BAD || r_status == ST_OVER))
        else $error("give-up without a drop");

    // length is reported only for completed frames
    a_flen_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OLD && r_status != ST_NEW) |-> (r_flen == '0))
        else $error("frame length on a non-final beat");

    // trailer position never runs past its last slot
    a_trail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trail_idx <= TI_LAST)
        else $error("trailer index out of range");

    // a completed or dropped frame leaves the framer hunting with empty count
    a_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_status != ST_IGNORED && n_status != ST_BYTE)
        |=> (r_phase == PH_HUNT && r_byte_cnt == '0))
        else $error("framer not reset after frame end");

    // good frame clears the fail counter
    a_good_clears_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (n_status == ST_OLD || n_status == ST_NEW)) |=> (r_fail_cnt == '0))
        else $error("fail count kept after good frame");

endmodule
